// ===== src/hne_pkg.sv =====
// Shared types and constants for the HTML numeric entity encoder.
// No dependencies; imported by the encoder and its checker.
package hne_pkg;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CONV  = 8'b0000_0010,
    ST_SKIP  = 8'b0000_0100,
    ST_AMP   = 8'b0000_1000,
    ST_HASH  = 8'b0001_0000,
    ST_DIGIT = 8'b0010_0000,
    ST_SEMI  = 8'b0100_0000
  } state_t;

  localparam logic [7:0]  CH_AMP       = 8'h26;  // '&'
  localparam logic [7:0]  CH_HASH      = 8'h23;  // '#'
  localparam logic [7:0]  CH_SEMI      = 8'h3B;  // ';'
  localparam logic [31:0] PRINT_LO     = 32'd31;
  localparam logic [31:0] PRINT_HI     = 32'd127;
  localparam logic [31:0] BACKSLASH    = 32'd92;
  localparam logic [31:0] DEC_LIMIT    = 32'd1000000;
  localparam int          BIN_W        = 20;     // 999999 fits in 20 bits
  localparam int          BCD_DIGITS   = 6;
  localparam int          NIBBLES      = 8;

  // ASCII for one digit: 0-9 then lowercase a-f.
  function automatic logic [7:0] digit_char(input logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) c = 8'h30 + {4'b0000, d};
    else           c = 8'h57 + {4'b0000, d};
    return c;
  endfunction

endpackage

// ===== src/html_numeric_entity_encoder.sv =====
// HTML numeric entity encoder: one code point in, its escaped bytes out.
// Depends on hne_pkg (state type, character constants, digit_char).
//
// Channel  | Direction | Payload                         | Handshake
// ---------+-----------+---------------------------------+-----------------------
// s_*      | in        | tdata[31:0] = code_point        | s_tvalid / s_tready
// m_*      | out       | tdata[7:0] = out_byte, tlast    | m_tvalid / m_tready
// cfg_*    | in        | cfg_data = use_decimal          | cfg_valid / cfg_ready
//
// Flow: a printable code point is loaded into the output register at its accept
// edge, so the next one can follow at once if m_tready is high. An escaped value
// is first converted when decimal (double dabble, one binary bit per cycle), then
// drops leading zero digits one per cycle, then sends its bytes ('&', '#',
// digits, ';') one per cycle while m_tready is high; no new code point is taken
// before its ';' is loaded.
// Reset: synchronous, active high; use_decimal returns to 1.
// Stalls: a low m_tready holds the pending beat and the byte states, while
// conversion and zero dropping go on; input is taken only when idle and the
// output register is free or being drained.
module html_numeric_entity_encoder (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] code_point
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [7:0] out_byte
  output logic        m_tlast,   // last byte of this code point
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data   // use_decimal
);
  import hne_pkg::*;

  state_t      state;
  logic        use_decimal;
  logic [31:0] dig;              // digit shift register, most significant nibble out first
  logic [BIN_W-1:0] bin;         // binary value being converted to BCD
  logic [4:0]  cnt;              // conversion steps or digits left, minus one

  logic        out_free;
  logic        s_fire;
  logic        printable;
  logic        dec_mode;
  logic        beat_load;
  logic [4*BCD_DIGITS-1:0] bcd_adj;

  assign out_free  = !m_tvalid || m_tready;
  assign s_tready  = (state == ST_IDLE) && out_free;
  assign s_fire    = s_tvalid && s_tready;
  assign cfg_ready = 1'b1;

  assign printable = (s_tdata > PRINT_LO) && (s_tdata < PRINT_HI) && (s_tdata != BACKSLASH);
  assign dec_mode  = use_decimal && (s_tdata < DEC_LIMIT);

  // A new beat enters the output register this cycle.
  assign beat_load = (s_fire && printable) ||
                     (out_free && (state == ST_AMP || state == ST_HASH ||
                                   state == ST_DIGIT || state == ST_SEMI));

  // Add 3 to every BCD digit of 5 or more before the next shift.
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (dig[4*i +: 4] >= 4'd5) bcd_adj[4*i +: 4] = dig[4*i +: 4] + 4'd3;
      else                       bcd_adj[4*i +: 4] = dig[4*i +: 4];
    end
  end

  // Configuration register: keep bit 0 of the write.
  always_ff @(posedge clk) begin
    if (rst) begin
      use_decimal <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      use_decimal <= cfg_data;
    end
  end

  // Sequencer and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      cnt      <= '0;
    end else begin
      // raise on a new beat, drop the beat once taken
      if (beat_load)     m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (printable) begin
              m_tdata  <= s_tdata[7:0];
              m_tlast  <= 1'b1;
            end else if (dec_mode) begin
              bin   <= s_tdata[BIN_W-1:0];
              dig   <= '0;
              cnt   <= 5'(BIN_W - 1);
              state <= ST_CONV;
            end else begin
              dig   <= s_tdata;
              cnt   <= 5'(NIBBLES - 1);
              state <= ST_SKIP;
            end
          end
        end
        ST_CONV: begin
          // shift one binary bit into the BCD digits
          dig[4*BCD_DIGITS-1:0] <= {bcd_adj[4*BCD_DIGITS-2:0], bin[BIN_W-1]};
          bin                   <= {bin[BIN_W-2:0], 1'b0};
          if (cnt == 5'd0) begin
            cnt   <= 5'(NIBBLES - 1);
            state <= ST_SKIP;
          end else begin
            cnt <= cnt - 5'd1;
          end
        end
        ST_SKIP: begin
          // drop leading zero digits, keep at least one
          if (dig[31:28] == 4'd0 && cnt != 5'd0) begin
            dig <= {dig[27:0], 4'd0};
            cnt <= cnt - 5'd1;
          end else begin
            state <= ST_AMP;
          end
        end
        ST_AMP: begin
          if (out_free) begin
            m_tdata  <= CH_AMP;
            m_tlast  <= 1'b0;
            state    <= ST_HASH;
          end
        end
        ST_HASH: begin
          if (out_free) begin
            m_tdata  <= CH_HASH;
            m_tlast  <= 1'b0;
            state    <= ST_DIGIT;
          end
        end
        ST_DIGIT: begin
          if (out_free) begin
            m_tdata  <= digit_char(dig[31:28]);
            m_tlast  <= 1'b0;
            dig      <= {dig[27:0], 4'd0};
            if (cnt == 5'd0) state <= ST_SEMI;
            else             cnt   <= cnt - 5'd1;
          end
        end
        ST_SEMI: begin
          if (out_free) begin
            m_tdata  <= CH_SEMI;
            m_tlast  <= 1'b1;
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== src/hne_checker.sv =====
// Port-level checks for the HTML numeric entity encoder, bound to its top level.
// Depends on hne_pkg for the printable-range constants.
module hne_port_checks (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [31:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [7:0]  m_tdata,
  input logic        m_tlast
);
  import hne_pkg::*;

  // A stalled beat holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled output beat changed");

  // Input is taken only when the output register can take a new beat.
  a_room: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |-> !m_tvalid || m_tready)
    else $error("input accepted while output register blocked");

  // A printable code point comes out next cycle as a single last beat.
  a_pass: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tdata > PRINT_LO && s_tdata < PRINT_HI && s_tdata != BACKSLASH
    |=> m_tvalid && m_tlast && m_tdata == $past(s_tdata[7:0]))
    else $error("pass-through byte wrong");

  // Mid-run, no new input is taken.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input accepted in the middle of an escape run");

endmodule

bind html_numeric_entity_encoder hne_port_checks u_hne_port_checks (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

// ===== sim/hne_checker.sv =====
// Scoreboard for the HTML numeric entity encoder: watches all three channels,
// predicts the escaped bytes of every code point and compares each output beat.
// Depends on hne_pkg for the character and range constants.
`timescale 1ns / 1ps

module hne_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          fail_count,
  output int          pending,
  output int          points_seen,
  output int          bytes_seen
);
  import hne_pkg::*;

  localparam logic [7:0] CHR_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CHR_LOWER_A = 8'h61;  // 'a'

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } enc_byte_t;

  enc_byte_t  escaped_bytes[$];
  logic       dec_mode;

  task automatic push_byte(input logic [7:0] ch, input logic last);
    enc_byte_t b;
    b.ch   = ch;
    b.last = last;
    escaped_bytes.push_back(b);
  endtask

  // Expand one code point into the bytes the encoder must send.
  task automatic predict_entity(input logic [31:0] cp);
    logic [7:0]  digits [0:9];
    logic [31:0] v;
    logic [31:0] rem;
    logic [3:0]  nib;
    int          nd;
    v = cp;
    if (cp > PRINT_LO && cp < PRINT_HI && cp != BACKSLASH) begin
      push_byte(cp[7:0], 1'b1);
    end else begin
      if (dec_mode && cp < DEC_LIMIT) begin
        for (nd = 0; nd == 0 || v != 0; nd++) begin
          rem        = v % 10;
          digits[nd] = CHR_ZERO + rem[7:0];
          v          = v / 10;
        end
      end else begin
        for (nd = 0; nd == 0 || v != 0; nd++) begin
          nib        = v[3:0];
          digits[nd] = (nib < 4'd10) ? CHR_ZERO + {4'h0, nib}
                                     : CHR_LOWER_A + {4'h0, nib} - 8'd10;
          v          = v >> 4;
        end
      end
      push_byte(CH_AMP, 1'b0);
      push_byte(CH_HASH, 1'b0);
      for (int i = nd - 1; i >= 0; i--) push_byte(digits[i], 1'b0);
      push_byte(CH_SEMI, 1'b1);
    end
  endtask

  always @(posedge clk) begin
    enc_byte_t want;
    if (rst) begin
      escaped_bytes.delete();
      dec_mode = 1'b1;
    end else begin
      // a code point taken at this edge still sees the old mode
      if (s_tvalid && s_tready) begin
        predict_entity(s_tdata);
        points_seen++;
      end
      if (cfg_valid && cfg_ready) dec_mode = cfg_data;
      if (m_tvalid && m_tready) begin
        bytes_seen++;
        if (escaped_bytes.size() == 0) begin
          $error("unexpected output beat: out_byte %h last %b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = escaped_bytes.pop_front();
          if (m_tdata !== want.ch) begin
            $error("out_byte mismatch: expected %h actual %h", want.ch, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("last mismatch: expected %b actual %b", want.last, m_tlast);
            fail_count++;
          end
        end
      end
    end
    pending = escaped_bytes.size();
  end

endmodule

// ===== sim/tb_html_numeric_entity_encoder.sv =====
// Testbench top for the HTML numeric entity encoder: drives code points and
// mode writes, pulls output beats under varying backpressure, gives the verdict.
// Depends on html_numeric_entity_encoder, hne_checker and hne_pkg.
`timescale 1ns / 1ps

module tb_html_numeric_entity_encoder;

  localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
  localparam int DRAIN_CYCLES = 40;      // extra idle time after the scoreboard empties
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASES       = 6;
  localparam int PHASE_POINTS = 73;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        s_tvalid  = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata   = '0;
  logic        m_tvalid;
  logic        m_tready  = 1'b0;
  logic [7:0]  m_tdata;
  logic        m_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data  = 1'b0;

  int fail_count;
  int pending;
  int points_seen;
  int bytes_seen;
  int cycle_count = 0;

  // Idle odds in percent, set by the main sequence per phase.
  int send_idle = 0;
  int recv_idle = 0;
  bit hold_req  = 1'b0;

  // Directed code points: range edges, backslash, decimal/hex limits.
  logic [31:0] dec_points [0:11] = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd31, 32'd32,
                                     32'd65, 32'd126, 32'd127, 32'd92,
                                     32'd999999, 32'd1000000};
  logic [31:0] hex_points [0:11] = '{32'd0, 32'd15, 32'd16, 32'd255, 32'd92,
                                     32'd126, 32'd127, 32'd65535, 32'd1000000,
                                     32'd999999, 32'h8000_0000, 32'hFFFF_FFFF};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  html_numeric_entity_encoder u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  hne_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tlast     (m_tlast),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .points_seen (points_seen),
    .bytes_seen  (bytes_seen)
  );

  // Hard stop if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("html_numeric_entity_encoder regression: fail");
      $finish;
    end
  end

  // Receiver: drop tready at random; on request hold it low once for a long
  // stretch so the encoder backs up and stalls its input.
  initial begin
    bit held;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Offer one code point; called and returns at a falling edge.
  // Insert random gaps first, then hold the beat until it is taken.
  task automatic send_code(input logic [31:0] cp);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= cp;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Write use_decimal once the encoder has drained completely.
  task automatic write_mode(input logic dec);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= dec;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random code point, weighted toward the interesting regions.
  function automatic logic [31:0] random_code();
    logic [31:0] cp;
    case ($urandom_range(9))
      0, 1:    cp = $urandom_range(126, 32);       // printable pass-through
      2:       cp = $urandom_range(31, 0);         // control characters
      3: begin
        case ($urandom_range(5))
          0:       cp = 32'd92;
          1:       cp = 32'd127;
          2:       cp = 32'd31;
          3:       cp = 32'd32;
          4:       cp = 32'd126;
          default: cp = 32'd0;
        endcase
      end
      4:       cp = $urandom_range(32'hFFFF, 128);
      5:       cp = $urandom_range(32'h10FFFF, 32'h10000);
      6:       cp = $urandom_range(1000999, 999000); // decimal cutoff
      9:       cp = $urandom_range(999, 0);
      default: cp = $urandom();                     // full 32-bit range
    endcase
    return cp;
  endfunction

  initial begin
    // Hold reset, then release it at a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_idle = 8;
    recv_idle = 66;

    // Directed: decimal mode straight out of reset, then hex mode.
    foreach (dec_points[i]) send_code(dec_points[i]);
    write_mode(1'b0);
    foreach (hex_points[i]) send_code(hex_points[i]);

    // Random phases: alternate the mode, move the idle mix every two phases.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_mode((ph % 2) == 0);
      case (ph / 2)
        0: begin
          send_idle = 8;
          recv_idle = 66;
        end
        1: begin
          send_idle = 66;
          recv_idle = 8;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      // Stall the output early on while input keeps coming.
      if (ph == 0) hold_req = 1'b1;
      for (int n = 0; n < PHASE_POINTS; n++) send_code(random_code());
    end

    // Drain and let the pipeline settle.
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d code points, %0d encoded bytes, decimal and hex modes",
             points_seen, bytes_seen);
    $display("backpressure: sender-heavy, receiver-heavy, none; one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (fail_count == 0 && pending == 0) begin
      $display("html_numeric_entity_encoder regression: pass");
    end else begin
      $display("html_numeric_entity_encoder regression: fail");
    end
    $finish;
  end

endmodule
